FILE: design/rgb_3x3_convolution_clamped_edges_unit_assert.svh
// Assertion macros for the 3x3 RGB convolution unit.
// Included by the top level; no other dependencies.
`ifndef RGB_3X3_CONVOLUTION_CLAMPED_EDGES_UNIT_ASSERT_SVH
`define RGB_3X3_CONVOLUTION_CLAMPED_EDGES_UNIT_ASSERT_SVH

// Implication checked on every rising clock edge outside reset
`define RGBC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgbc assertion failed");

// Next-cycle implication checked outside reset
`define RGBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgbc assertion failed");

`endif

FILE: design/rgbc_pkg.sv
// Package for the 3x3 RGB convolution unit: widths, constants, types.
// No dependencies.
`default_nettype none
package rgbc_pkg;
  localparam int MaxWidth     = 1024;
  localparam int MaxHeight    = 4096;
  localparam int CoefFracBits = 12;
  localparam int ColW  = $clog2(MaxWidth);
  localparam int LineW = $clog2(MaxHeight) + 1;
  localparam int NumRegs = 5;

  typedef enum logic [2:0] {
    REG_COEF_TOP = 3'd0,
    REG_COEF_MID = 3'd1,
    REG_COEF_BOT = 3'd2,
    REG_WIDTH    = 3'd3,
    REG_HEIGHT   = 3'd4
  } reg_idx_e;

  typedef logic [23:0] pix_t;

  // one column of the window, index 0 is the top row
  typedef struct packed {
    pix_t bot;
    pix_t mid;
    pix_t top;
  } col_t;

  // control from the front end to the filter stage
  typedef struct packed {
    logic        valid;
    logic        last;
    logic [47:0] crow0;
    logic [47:0] crow1;
    logic [47:0] crow2;
  } ctrl_t;
endpackage
`default_nettype wire

FILE: design/rgbc_if.sv
// Valid/ready stream interfaces for pixels, results and configuration.
// No dependencies.
`default_nettype none
interface rgbc_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pix_red;
  logic [7:0] pix_green;
  logic [7:0] pix_blue;
  logic       is_flush;
  modport source (output valid, pix_red, pix_green, pix_blue, is_flush, input ready);
  modport sink   (input valid, pix_red, pix_green, pix_blue, is_flush, output ready);
endinterface

interface rgbc_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_end;
  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

interface rgbc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: design/rgbc_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rgbc_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: design/rgbc_cell.sv
// One window cell: holds a column of three pixels and shifts it on.
// Depends on rgbc_pkg.
`default_nettype none
module rgbc_cell
  import rgbc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic clr_i,
  input  wire logic en_i,
  input  wire col_t col_i,
  output col_t      col_o
);
  col_t col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (clr_i) begin
      col_q <= '0;
    end else if (en_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;
endmodule
`default_nettype wire

FILE: design/rgbc_mac.sv
// Per-channel filter: nine products, registered, then sum, truncate, clamp.
// Depends on rgbc_pkg.
`default_nettype none
module rgbc_mac
  import rgbc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [71:0] pix_i,   // nine 8-bit taps, col*3+row
  input  wire logic [47:0] crow0_i,
  input  wire logic [47:0] crow1_i,
  input  wire logic [47:0] crow2_i,
  output logic [7:0]       res_o
);
  logic signed [24:0] prod_q [9];
  logic signed [28:0] acc;
  logic [47:0]        crow [3];

  assign crow[0] = crow0_i;
  assign crow[1] = crow1_i;
  assign crow[2] = crow2_i;

  // products into a register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          prod_q[c*3+r] <= $signed({1'b0, pix_i[(c*3+r)*8 +: 8]})
                         * $signed(crow[r][c*16 +: 16]);
        end
      end
    end
  end

  // sum, truncate, clamp
  always_comb begin
    acc = '0;
    for (int k = 0; k < 9; k++) acc = acc + 29'(prod_q[k]);
    if (acc <= 0) begin
      res_o = 8'd0;
    end else if (acc[28:CoefFracBits] > 255) begin
      res_o = 8'd255;
    end else begin
      res_o = acc[CoefFracBits +: 8];
    end
  end
endmodule
`default_nettype wire

FILE: design/rgb_3x3_convolution_clamped_edges_unit.sv
// Top level of the 3x3 RGB convolution with replicated borders.
// Depends on rgbc_pkg, rgbc_if, rgbc_ram, rgbc_cell, rgbc_mac, the assert header.
//
// Channel | Dir | Beat
// pix_in  | in  | one pixel or flush item
// res_out | out | one filtered pixel
// cfg     | in  | one register write
//
// One item a cycle. Three stages: line-store read, window shift and
// products, sum/clamp into the output register. Stalls freeze all stages.
// Reset gives the identity kernel and 1024x1024; line stores need no clearing.
`default_nettype none
`include "rgb_3x3_convolution_clamped_edges_unit_assert.svh"
module rgb_3x3_convolution_clamped_edges_unit
  import rgbc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rgbc_pix_if.sink   pix_in,
  rgbc_res_if.source res_out,
  rgbc_cfg_if.sink   cfg
);
  logic [47:0] crow_q [3];
  logic [10:0] width_q;
  logic [12:0] height_q;
  logic [ColW-1:0]  col_q, col_d;
  logic [LineW-1:0] line_q, line_d;
  logic             restart;

  // stage valids: s1 = read issued, s2 = window shifted, s3 = output reg
  logic s1_q, s2_q, s3_q;
  logic adv;
  logic acc_in;

  assign adv        = !s3_q || res_out.ready;
  assign pix_in.ready = adv;
  assign acc_in     = pix_in.valid && adv;
  assign cfg.ready  = 1'b1;
  assign restart    = cfg.valid && (cfg.index == REG_WIDTH || cfg.index == REG_HEIGHT);

  // effective dimensions
  logic [ColW:0]  w;
  logic [LineW:0] h;
  always_comb begin
    if (width_q == '0) w = (ColW+1)'(1);
    else if (width_q > 11'(MaxWidth)) w = (ColW+1)'(MaxWidth);
    else w = (ColW+1)'(width_q);
    if (height_q == '0) h = (LineW+1)'(1);
    else if (height_q > 13'(MaxHeight)) h = (LineW+1)'(MaxHeight);
    else h = (LineW+1)'(height_q);
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crow_q[0] <= '0;
      crow_q[1] <= 48'h0000_1000_0000;
      crow_q[2] <= '0;
      width_q   <= 11'd1024;
      height_q  <= 13'd1024;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_COEF_TOP: crow_q[0] <= cfg.data;
        REG_COEF_MID: crow_q[1] <= cfg.data;
        REG_COEF_BOT: crow_q[2] <= cfg.data;
        REG_WIDTH:    width_q   <= cfg.data[10:0];
        REG_HEIGHT:   height_q  <= cfg.data[12:0];
        default: ;
      endcase
    end
  end

  // position of this item and its output classification
  logic c_nz, c_ge2, out_v, out_last;
  logic [ColW:0]  ox;
  logic [LineW:0] oy;
  always_comb begin
    c_nz  = col_q != '0;
    c_ge2 = col_q > ColW'(1);
    if (c_nz) begin
      out_v = (line_q >= LineW'(1)) && (({1'b0, line_q} - 1'b1) < h);
      ox    = {1'b0, col_q} - 1'b1;
      oy    = {1'b0, line_q} - 1'b1;
    end else begin
      out_v = (line_q >= LineW'(2)) && (({1'b0, line_q} - (LineW+1)'(2)) < h);
      ox    = w - 1'b1;
      oy    = {1'b0, line_q} - (LineW+1)'(2);
    end
    out_last = out_v && (ox == w - 1'b1) && (oy == h - 1'b1);
    if (out_last) begin
      col_d  = '0;
      line_d = '0;
    end else if (({1'b0, col_q} + 1'b1) >= w) begin
      col_d  = '0;
      line_d = line_q + 1'b1;
    end else begin
      col_d  = col_q + 1'b1;
      line_d = line_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      line_q <= '0;
    end else if (restart) begin
      col_q  <= '0;
      line_q <= '0;
    end else if (acc_in) begin
      col_q  <= col_d;
      line_q <= line_d;
    end
  end

  // line stores: read at column, written back from the s1 registers
  pix_t pin;
  assign pin = {pix_in.pix_red, pix_in.pix_green, pix_in.pix_blue};
  pix_t old_rd, new_rd;
  logic [ColW-1:0] s1_col_q;
  logic [LineW-1:0] s1_line_q;
  pix_t s1_pin_q;
  logic s1_cnz_q, s1_cge2_q, s1_ov_q, s1_last_q;
  logic wr_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_q <= 1'b0;
    else if (restart) s1_q <= 1'b0;
    else if (adv) s1_q <= acc_in;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_col_q  <= col_q;
      s1_line_q <= line_q;
      s1_pin_q  <= pin;
      s1_cnz_q  <= c_nz;
      s1_cge2_q <= c_ge2;
      s1_ov_q   <= out_v;
      s1_last_q <= out_last;
    end
  end

  // bypass: consecutive items share a column when the width is one or after the frame's last output
  pix_t fwd_new_q, fwd_old_q;
  logic fwd_hit_q;
  pix_t new_cur;
  assign wr_en = s1_q && adv && ((LineW+1)'(s1_line_q) < h);

  rgbc_ram #(.Width(24), .Depth(MaxWidth)) u_ram_old (
    .clk_i, .we_i(wr_en && s1_line_q != '0), .waddr_i(s1_col_q), .wdata_i(new_cur),
    .re_i(adv), .raddr_i(col_q), .rdata_o(old_rd)
  );
  rgbc_ram #(.Width(24), .Depth(MaxWidth)) u_ram_new (
    .clk_i, .we_i(wr_en), .waddr_i(s1_col_q), .wdata_i(s1_pin_q),
    .re_i(adv), .raddr_i(col_q), .rdata_o(new_rd)
  );
  // forward a write to the same column read in the same cycle
  always_ff @(posedge clk_i) begin
    if (adv) begin
      fwd_hit_q <= wr_en && (s1_col_q == col_q);
      fwd_new_q <= s1_pin_q;
      fwd_old_q <= new_cur;
    end
  end
  pix_t n_rd, o_rd;
  assign n_rd    = fwd_hit_q ? fwd_new_q : new_rd;
  assign o_rd    = fwd_hit_q ? fwd_old_q : old_rd;
  assign new_cur = n_rd;

  // column triple
  col_t cur;
  always_comb begin
    if (s1_line_q == '0) begin
      cur = '{bot: s1_pin_q, mid: s1_pin_q, top: s1_pin_q};
    end else begin
      cur.mid = n_rd;
      cur.top = (s1_line_q >= LineW'(2) && h >= (LineW+1)'(2)) ? o_rd : n_rd;
      cur.bot = ((LineW+1)'(s1_line_q) < h) ? s1_pin_q : n_rd;
    end
  end

  // chain of two cells; u_c2 holds the newest column
  col_t c2, c1;
  logic shift;
  assign shift = s1_q && adv;
  rgbc_cell u_c2 (.clk_i, .rst_ni, .clr_i(restart), .en_i(shift), .col_i(cur), .col_o(c2));
  rgbc_cell u_c1 (.clk_i, .rst_ni, .clr_i(restart), .en_i(shift), .col_i(c2),  .col_o(c1));

  // window for the output pixel, edge columns replicated
  col_t wl, wm, wr;
  always_comb begin
    if (s1_cnz_q) begin
      wl = s1_cge2_q ? c1 : c2;
      wm = c2;
      wr = cur;
    end else begin
      wl = (w >= (ColW+1)'(2)) ? c1 : c2;
      wm = c2;
      wr = c2;
    end
  end
  logic [71:0] win_r, win_g, win_b;
  always_comb begin
    win_r = {wr.bot[23:16], wr.mid[23:16], wr.top[23:16], wm.bot[23:16], wm.mid[23:16],
             wm.top[23:16], wl.bot[23:16], wl.mid[23:16], wl.top[23:16]};
    win_g = {wr.bot[15:8], wr.mid[15:8], wr.top[15:8], wm.bot[15:8], wm.mid[15:8],
             wm.top[15:8], wl.bot[15:8], wl.mid[15:8], wl.top[15:8]};
    win_b = {wr.bot[7:0], wr.mid[7:0], wr.top[7:0], wm.bot[7:0], wm.mid[7:0],
             wm.top[7:0], wl.bot[7:0], wl.mid[7:0], wl.top[7:0]};
  end

  // products stage and output register
  logic s2_last_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= 1'b0;
      s3_q <= 1'b0;
    end else if (adv) begin
      s2_q <= shift && s1_ov_q;
      s3_q <= s2_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_last_q <= s1_last_q;
    end
  end

  logic [7:0] r_s, g_s, b_s;
  rgbc_mac u_mr (.clk_i, .en_i(adv), .pix_i(win_r), .crow0_i(crow_q[0]), .crow1_i(crow_q[1]),
                 .crow2_i(crow_q[2]), .res_o(r_s));
  rgbc_mac u_mg (.clk_i, .en_i(adv), .pix_i(win_g), .crow0_i(crow_q[0]), .crow1_i(crow_q[1]),
                 .crow2_i(crow_q[2]), .res_o(g_s));
  rgbc_mac u_mb (.clk_i, .en_i(adv), .pix_i(win_b), .crow0_i(crow_q[0]), .crow1_i(crow_q[1]),
                 .crow2_i(crow_q[2]), .res_o(b_s));

  logic [7:0] or_q, og_q, ob_q;
  logic       oe_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      or_q <= r_s;
      og_q <= g_s;
      ob_q <= b_s;
      oe_q <= s2_last_q;
    end
  end

  assign res_out.valid     = s3_q;
  assign res_out.out_red   = or_q;
  assign res_out.out_green = og_q;
  assign res_out.out_blue  = ob_q;
  assign res_out.frame_end = oe_q;

  `RGBC_ASSERT_NEXT(a_hold, clk_i, rst_ni, res_out.valid && !res_out.ready, res_out.valid)
  `RGBC_ASSERT_IMP(a_stall, clk_i, rst_ni, res_out.valid && !res_out.ready, !pix_in.ready)
  `RGBC_ASSERT_NEXT(a_shift, clk_i, rst_ni, s2_q && adv, s3_q)
endmodule
`default_nettype wire
